@@ rtl/scr_pkg.sv @@
// Shared constants, controller states and command/status types for the stable counting rank block.
package scr_pkg;

    localparam int KEY_BITS    = 8;
    localparam int KEY_W       = 8;
    localparam int NUM_BUCKETS = 1 << KEY_BITS;
    localparam int CNT_W       = 17;
    localparam int RANK_W      = 16;
    localparam int MAX_KEYS    = 65536;
    localparam int TOTAL_W     = $clog2(MAX_KEYS + 1);

    localparam logic KIND_COUNT = 1'b0;
    localparam logic KIND_RANK  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_APPLY,
        ST_SCAN_RD,
        ST_SCAN_WR
    } state_t;

    typedef struct packed {
        logic capture;   // latch incoming request
        logic item_rd;   // read bucket of latched key
        logic apply;     // count / rank update of latched key
        logic scan_rd;   // read bucket at scan index
        logic scan_wr;   // write prefix sum at scan index
    } scr_cmd_t;

    typedef struct packed {
        logic rank_item;  // latched request yields a result
        logic end_count;  // latched request closes the count pass
        logic out_free;   // output register can take a result
        logic scan_last;  // scan index at final bucket
    } scr_status_t;

endpackage

@@ rtl/scr_ctrl.sv @@
// Controller state machine for the stable counting rank block.
module scr_ctrl
    import scr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  scr_status_t status,
    output scr_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (!status.rank_item || status.out_free)
                begin
                    state_next = status.end_count ? ST_SCAN_RD : ST_IDLE;
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_WR;
            end
            ST_SCAN_WR:
            begin
                state_next = status.scan_last ? ST_IDLE : ST_SCAN_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_LOOKUP:
            begin
                cmd.item_rd = 1'b1;
            end
            ST_APPLY:
            begin
                // hold a result until the output register drains
                cmd.apply = !status.rank_item || status.out_free;
            end
            ST_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
            end
            ST_SCAN_WR:
            begin
                cmd.scan_wr = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/scr_dpath.sv @@
// Datapath: bucket memory, counters, prefix scan and output register.
module scr_dpath
    import scr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                kind,
    input  logic [KEY_W-1:0]    key,
    input  logic                last,
    input  scr_cmd_t            cmd,
    output scr_status_t         status,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [RANK_W-1:0]   rank,
    output logic                final_res,
    output logic                overflow
);

    logic [CNT_W-1:0]       mem [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0] valid_reg;

    logic                   kind_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic                   last_reg;

    logic [CNT_W-1:0]       rd_data_reg;
    logic                   rd_valid_reg;
    logic [KEY_BITS-1:0]    rd_addr;
    logic                   rd_en;

    logic [KEY_BITS-1:0]    idx_reg;
    logic [CNT_W-1:0]       run_reg;
    logic [TOTAL_W-1:0]     total_reg;
    logic                   ovf_reg;
    logic                   cursors_reg;

    logic                   out_valid_reg;
    logic [RANK_W-1:0]      rank_reg;
    logic                   final_reg;
    logic                   ovf_out_reg;

    logic [CNT_W-1:0]       here;
    logic                   do_count;
    logic                   do_rank;
    logic                   at_capacity;
    logic                   clear_all;
    logic                   we;
    logic [KEY_BITS-1:0]    wr_addr;
    logic [CNT_W-1:0]       wr_data;

    // unwritten buckets read as zero
    assign here        = rd_valid_reg ? rd_data_reg : '0;
    assign at_capacity = (total_reg >= TOTAL_W'(MAX_KEYS));
    assign do_count    = cmd.apply && (kind_reg == KIND_COUNT) && !cursors_reg;
    assign do_rank     = cmd.apply && (kind_reg == KIND_RANK) && cursors_reg;
    assign clear_all   = do_rank && last_reg;

    assign rd_en   = cmd.item_rd || cmd.scan_rd;
    assign rd_addr = cmd.scan_rd ? idx_reg : key_reg;
    assign we      = (do_count && !at_capacity) || do_rank || cmd.scan_wr;
    assign wr_addr = cmd.scan_wr ? idx_reg : key_reg;
    assign wr_data = cmd.scan_wr ? run_reg : here + CNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind;
            key_reg  <= key[KEY_BITS-1:0];
            last_reg <= last;
        end
        if (do_rank)
        begin
            rank_reg    <= here[RANK_W-1:0];
            final_reg   <= last_reg;
            ovf_out_reg <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            idx_reg       <= '0;
            run_reg       <= '0;
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            cursors_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear_all)
            begin
                valid_reg   <= '0;
                total_reg   <= '0;
                ovf_reg     <= 1'b0;
                cursors_reg <= 1'b0;
            end
            else
            begin
                if (we)
                begin
                    valid_reg[wr_addr] <= 1'b1;
                end
                if (do_count)
                begin
                    if (at_capacity)
                    begin
                        ovf_reg <= 1'b1;
                    end
                    else
                    begin
                        total_reg <= total_reg + TOTAL_W'(1);
                    end
                end
                if (cmd.scan_wr)
                begin
                    idx_reg <= idx_reg + KEY_BITS'(1);
                    if (status.scan_last)
                    begin
                        run_reg     <= '0;
                        cursors_reg <= 1'b1;
                    end
                    else
                    begin
                        run_reg <= run_reg + here;
                    end
                end
            end

            if (do_rank)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.rank_item = (kind_reg == KIND_RANK) && cursors_reg;
    assign status.end_count = (kind_reg == KIND_COUNT) && !cursors_reg && last_reg;
    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.scan_last = (idx_reg == {KEY_BITS{1'b1}});

    assign out_valid = out_valid_reg;
    assign rank      = rank_reg;
    assign final_res = final_reg;
    assign overflow  = ovf_out_reg;

endmodule

@@ rtl/stable_counting_rank.sv @@
// Top level of the stable counting rank block.
//
// Usage: stream a key set twice on the input channel (in_valid/in_ready).
// First pass: requests with kind = 0, the final one flagged by last; these
// build a per-bucket histogram and return nothing. The last count request
// starts a prefix scan that turns the histogram into bucket cursors.
// Second pass: requests with kind = 1; each returns one result on the
// output channel (out_valid/out_ready) with the stable rank, final_res set
// on the last one, and overflow set if the count pass went past capacity.
// Requests that do not fit the current pass are dropped without a result.
// Each request runs through accept in idle, memory read and update before
// the next is accepted; the registered bucket memory read sits before each update.
// A rank result is registered into the output register by its update step.
// The prefix scan after the last count request reads and writes each of the
// 256 buckets in turn, during which no request is accepted.
// Reset clears all buckets at once (per-bucket valid bits), the counters
// and output valid bit. The last rank request likewise clears buckets and counters.
// A stalled receiver holds the result in the output register; the next
// rank request then waits in its update step until the register drains.
module stable_counting_rank
    import scr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                kind,
    input  logic [KEY_W-1:0]    key,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [RANK_W-1:0]   rank,
    output logic                final_res,
    output logic                overflow
);

    scr_cmd_t    cmd;
    scr_status_t status;

    scr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    scr_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .kind      (kind),
        .key       (key),
        .last      (last),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rank      (rank),
        .final_res (final_res),
        .overflow  (overflow)
    );

endmodule

@@ rtl/scr_checker.sv @@
// Port-level checks for the stable counting rank block, bound to the top level.
module scr_checker
    import scr_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                kind,
    input logic                out_valid,
    input logic                out_ready,
    input logic [RANK_W-1:0]   rank
);

    // stalled result stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_rank_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(rank))
        else $error("rank changed while stalled");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    // count requests never produce a result
    a_count_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == KIND_COUNT) |-> ##3 !$rose(out_valid))
        else $error("result from a count request");

endmodule

bind stable_counting_rank scr_checker u_scr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rank      (rank)
);
